>>> design/rlcf_pkg.sv
// Shared types and constants of the RGB LED command fader.
`default_nettype none

package rlcf_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int LEVEL_W = 12;
  localparam int VALUE_W = 10;

  localparam logic [7:0] FADE_STEP_RESET = 8'd20;
  localparam logic [7:0] FADE_LAST = 8'd254;
  localparam logic [7:0] FADE_TOP = 8'd255;
  localparam logic [1:0] PHASE_LAST = 2'd2;
  localparam logic [1:0] DIGITS_LAST = 2'd2;
  localparam logic [LEVEL_W-1:0] FULL_DUTY = 12'd4095;

  localparam logic [VALUE_W-1:0] VAL_RED_LO = 10'd100;
  localparam logic [VALUE_W-1:0] VAL_RED_HI = 10'd355;
  localparam logic [VALUE_W-1:0] VAL_GREEN_HI = 10'd511;
  localparam logic [VALUE_W-1:0] VAL_BLUE_HI = 10'd767;
  localparam logic [VALUE_W-1:0] BRIGHT_OFFSET = 10'd100;

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_C = 8'h63;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;

  typedef enum logic [2:0] {
    EV_TICK,
    EV_FULL,
    EV_FADE,
    EV_COLOR,
    EV_BRIGHT,
    EV_DIGIT,
    EV_OTHER
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [3:0] digit;
  } event_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_COLOR,
    MODE_BRIGHT,
    MODE_FADE
  } mode_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] digit_count;
  } back_status_t;

endpackage

`default_nettype wire

>>> design/rlcf_front.sv
// Front end: classifies each received byte or tick into an event.
`default_nettype none

module rlcf_front (
  input  wire logic            cmd,
  input  wire logic [7:0]      data_byte,
  output rlcf_pkg::event_t     ev
);

  always_comb begin
    ev.digit = data_byte[3:0];
    if (cmd) begin
      ev.kind = rlcf_pkg::EV_TICK;
    end else begin
      unique case (data_byte) inside
        rlcf_pkg::CH_A: ev.kind = rlcf_pkg::EV_FULL;
        rlcf_pkg::CH_F: ev.kind = rlcf_pkg::EV_FADE;
        rlcf_pkg::CH_C: ev.kind = rlcf_pkg::EV_COLOR;
        rlcf_pkg::CH_B: ev.kind = rlcf_pkg::EV_BRIGHT;
        [rlcf_pkg::CH_0:rlcf_pkg::CH_9]: ev.kind = rlcf_pkg::EV_DIGIT;
        default: ev.kind = rlcf_pkg::EV_OTHER;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/rlcf_queue.sv
// Short event queue between the front end and the back end.
`default_nettype none

module rlcf_queue #(
  parameter int DEPTH = rlcf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  rlcf_pkg::event_t      push_data,
  input  wire logic             pop,
  output logic                  q_valid,
  output rlcf_pkg::event_t      q_data,
  output rlcf_pkg::q_status_t   status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rlcf_pkg::event_t mem [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_FULL);
  assign status.empty = (count_r == '0);
  assign q_valid      = !status.empty;
  assign q_data       = mem[rptr_r];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && q_valid;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> design/rlcf_back.sv
// Back end: command state machine, fade sequencer and result register.
`default_nettype none

module rlcf_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata,
  input  wire logic                ev_valid,
  input  rlcf_pkg::event_t         ev,
  output logic                     ev_pop,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [39:0]              out_tdata,
  output logic                     out_tuser,
  output rlcf_pkg::back_status_t   status
);

  localparam int LW = rlcf_pkg::LEVEL_W;
  localparam int VW = rlcf_pkg::VALUE_W;

  typedef struct packed {
    logic [LW-1:0] blue;
    logic [LW-1:0] green;
    logic [LW-1:0] red;
  } levels_t;

  function automatic levels_t fade_levels(input logic [1:0] phase, input logic [7:0] idx);
    levels_t    lv;
    logic [7:0] inv;
    inv = rlcf_pkg::FADE_TOP - idx;
    lv  = '0;
    case (phase)
      2'd0: begin
        lv.red   = LW'(idx);
        lv.green = LW'(inv);
      end
      2'd1: begin
        lv.red  = LW'(inv);
        lv.blue = LW'(idx);
      end
      default: begin
        lv.green = LW'(idx);
        lv.blue  = LW'(inv);
      end
    endcase
    return lv;
  endfunction

  rlcf_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]      step_ticks_r;
  logic [1:0]      digit_count_r, digit_count_nxt;
  logic [VW-1:0]   acc_r, acc_nxt;
  logic            stopped_r, stopped_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [7:0]      index_r, index_nxt;
  logic [7:0]      tick_r, tick_nxt;
  levels_t         lv_r, lv_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [39:0]     out_data_r;
  logic            out_fading_r;

  logic            can_take, is_tick, is_digit, emit;
  logic [7:0]      limit;
  logic [8:0]      tick_inc;
  logic            step_due, last_step, fade_end, collect_done;
  logic [12:0]     acc_x10;
  logic [VW-1:0]   acc_new, bright;

  assign can_take     = !out_valid_r || out_tready;
  assign ev_pop       = ev_valid && can_take;
  assign is_tick      = (ev.kind == rlcf_pkg::EV_TICK);
  assign is_digit     = (ev.kind == rlcf_pkg::EV_DIGIT);
  assign limit        = (step_ticks_r == 8'd0) ? 8'd1 : step_ticks_r;
  assign tick_inc     = {1'b0, tick_r} + 9'd1;
  assign step_due     = (tick_inc >= {1'b0, limit});
  assign last_step    = (index_r >= rlcf_pkg::FADE_LAST);
  assign fade_end     = last_step && (phase_r >= rlcf_pkg::PHASE_LAST);
  assign collect_done = (digit_count_r == rlcf_pkg::DIGITS_LAST);
  assign acc_x10      = 13'({acc_r, 3'b000}) + 13'({acc_r, 1'b0}) + 13'(ev.digit);
  assign acc_new      = (!stopped_r && is_digit) ? acc_x10[VW-1:0] : acc_r;
  assign bright       = (acc_new >= rlcf_pkg::BRIGHT_OFFSET) ?
                        acc_new - rlcf_pkg::BRIGHT_OFFSET : '0;

  always_comb begin
    mode_nxt = mode_r;
    if (ev_pop) begin
      unique case (mode_r)
        rlcf_pkg::MODE_IDLE: begin
          case (ev.kind)
            rlcf_pkg::EV_FADE:   mode_nxt = rlcf_pkg::MODE_FADE;
            rlcf_pkg::EV_COLOR:  mode_nxt = rlcf_pkg::MODE_COLOR;
            rlcf_pkg::EV_BRIGHT: mode_nxt = rlcf_pkg::MODE_BRIGHT;
            default:             mode_nxt = rlcf_pkg::MODE_IDLE;
          endcase
        end
        rlcf_pkg::MODE_COLOR, rlcf_pkg::MODE_BRIGHT: begin
          if (!is_tick && collect_done) begin
            mode_nxt = rlcf_pkg::MODE_IDLE;
          end
        end
        rlcf_pkg::MODE_FADE: begin
          if (is_tick && step_due && fade_end) begin
            mode_nxt = rlcf_pkg::MODE_IDLE;
          end
        end
        default: mode_nxt = rlcf_pkg::MODE_IDLE;
      endcase
    end
  end

  always_comb begin
    digit_count_nxt = digit_count_r;
    acc_nxt         = acc_r;
    stopped_nxt     = stopped_r;
    phase_nxt       = phase_r;
    index_nxt       = index_r;
    tick_nxt        = tick_r;
    lv_nxt          = lv_r;
    emit            = 1'b0;
    if (ev_pop) begin
      unique case (mode_r)
        rlcf_pkg::MODE_IDLE: begin
          if (!is_tick) begin
            digit_count_nxt = '0;
            acc_nxt         = '0;
            stopped_nxt     = 1'b0;
            if (ev.kind == rlcf_pkg::EV_FULL) begin
              lv_nxt = {rlcf_pkg::FULL_DUTY, rlcf_pkg::FULL_DUTY, rlcf_pkg::FULL_DUTY};
              emit   = 1'b1;
            end else if (ev.kind == rlcf_pkg::EV_FADE) begin
              phase_nxt = '0;
              index_nxt = '0;
              tick_nxt  = '0;
              lv_nxt    = fade_levels(2'd0, 8'd0);
              emit      = 1'b1;
            end
          end
        end
        rlcf_pkg::MODE_COLOR, rlcf_pkg::MODE_BRIGHT: begin
          if (!is_tick) begin
            acc_nxt         = acc_new;
            stopped_nxt     = stopped_r || !is_digit;
            digit_count_nxt = digit_count_r + 2'd1;
            if (collect_done) begin
              digit_count_nxt = '0;
              if (mode_r == rlcf_pkg::MODE_BRIGHT) begin
                lv_nxt = {LW'(bright), LW'(bright), LW'(bright)};
                emit   = 1'b1;
              end else if (acc_new >= rlcf_pkg::VAL_RED_LO &&
                           acc_new <= rlcf_pkg::VAL_RED_HI) begin
                lv_nxt.red = LW'(rlcf_pkg::VAL_RED_HI - acc_new);
                emit       = 1'b1;
              end else if (acc_new > rlcf_pkg::VAL_RED_HI &&
                           acc_new <= rlcf_pkg::VAL_GREEN_HI) begin
                lv_nxt.green = LW'(rlcf_pkg::VAL_GREEN_HI - acc_new);
                emit         = 1'b1;
              end else if (acc_new > rlcf_pkg::VAL_GREEN_HI &&
                           acc_new <= rlcf_pkg::VAL_BLUE_HI) begin
                lv_nxt.blue = LW'(rlcf_pkg::VAL_BLUE_HI - acc_new);
                emit        = 1'b1;
              end
            end
          end
        end
        rlcf_pkg::MODE_FADE: begin
          if (is_tick) begin
            if (!step_due) begin
              tick_nxt = tick_inc[7:0];
            end else begin
              tick_nxt = '0;
              emit     = 1'b1;
              if (!last_step) begin
                index_nxt = index_r + 8'd1;
                lv_nxt    = fade_levels(phase_r, index_r + 8'd1);
              end else if (!fade_end) begin
                phase_nxt = phase_r + 2'd1;
                index_nxt = '0;
                lv_nxt    = fade_levels(phase_r + 2'd1, 8'd0);
              end
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= rlcf_pkg::MODE_IDLE;
      step_ticks_r  <= rlcf_pkg::FADE_STEP_RESET;
      digit_count_r <= '0;
      acc_r         <= '0;
      stopped_r     <= 1'b0;
      phase_r       <= '0;
      index_r       <= '0;
      tick_r        <= '0;
      lv_r          <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      mode_r        <= mode_nxt;
      digit_count_r <= digit_count_nxt;
      acc_r         <= acc_nxt;
      stopped_r     <= stopped_nxt;
      phase_r       <= phase_nxt;
      index_r       <= index_nxt;
      tick_r        <= tick_nxt;
      lv_r          <= lv_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        step_ticks_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r   <= {4'b0000, lv_nxt.blue, lv_nxt.green, lv_nxt.red};
      out_fading_r <= (mode_nxt == rlcf_pkg::MODE_FADE);
    end
  end

  assign out_tvalid         = out_valid_r;
  assign out_tdata          = out_data_r;
  assign out_tuser          = out_fading_r;
  assign status.mode        = mode_r;
  assign status.digit_count = digit_count_r;

endmodule

`default_nettype wire

>>> design/rgb_led_command_fader_core.sv
// Top level of the RGB LED command fader: front end, event queue and back end.
//
// The input stream carries received command bytes and one millisecond ticks;
// in_tuser is 1 for a tick and in_tdata holds the byte. The back end turns
// 'a', 'f', 'c' and 'b' commands and fade ticks into new red, green and blue
// duty values, sent on the output stream with out_tuser set while the fade
// sequence runs. Items that complete no command or fade step produce no output transaction.
// cfg_we with cfg_wdata sets the number of ticks between fade steps.
//
// Each item is classified and pushed into a short event queue in the cycle
// it is accepted; the back end takes one event per cycle and registers its
// result. Sustained throughput is one item per cycle while out_tready stays
// high. When out_tready is low the finished result is held and the back end
// stops taking events; the queue keeps accepting items until it is full,
// then in_tready drops. Reset clears the queue, all levels and the fade
// state, and sets the step interval to 20 ticks.
`default_nettype none

module rgb_led_command_fader_core #(
  parameter int QUEUE_DEPTH = rlcf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // red_duty, green_duty, blue_duty, zero fill
  output logic             out_tuser,  // fading
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  rlcf_pkg::event_t       front_ev;
  rlcf_pkg::event_t       q_ev;
  rlcf_pkg::q_status_t    q_st;
  rlcf_pkg::back_status_t back_st;
  logic                   q_valid;
  logic                   q_pop;

  assign in_tready = !q_st.full;

  rlcf_front u_front (
    .cmd       (in_tuser),
    .data_byte (in_tdata),
    .ev        (front_ev)
  );

  rlcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data (front_ev),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_ev),
    .status    (q_st)
  );

  rlcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .ev_valid   (q_valid),
    .ev         (q_ev),
    .ev_pop     (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .status     (back_st)
  );

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output valid or input stalled right after reset");

  a_fade_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (({2'b00, out_tdata[11:0]} + {2'b00, out_tdata[23:12]} +
        {2'b00, out_tdata[35:24]}) == 14'd255) &&
      (out_tdata[11:0] == 12'd0 || out_tdata[23:12] == 12'd0 ||
       out_tdata[35:24] == 12'd0))
    else $error("fade result does not split one full step over two channels");

  a_fade_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.mode == rlcf_pkg::MODE_FADE |-> back_st.digit_count == 2'd0)
    else $error("digit count left over while fading");

  a_pop_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_st.empty)
    else $error("back end took an event from an empty queue");

endmodule

`default_nettype wire
